[src/box_blur_3x3_edge_aware_defines.svh]
// Assertion macros for the 3x3 box blur.
`ifndef BOX_BLUR_3X3_EDGE_AWARE_DEFINES_SVH
`define BOX_BLUR_3X3_EDGE_AWARE_DEFINES_SVH

// Checked property, suspended while reset is held.
`define BB3_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked property, also during reset.
`define BB3_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/bb3_pkg.sv]
// Types and constants shared by the 3x3 box blur modules.
package bb3_pkg;

  localparam int PIX_W   = 8;
  localparam int RGB_W   = 3 * PIX_W;
  localparam int ROW_W   = 16;
  localparam int COL_W   = 10;
  localparam int WIDTH_W = 11;
  localparam int SUM_W   = 12;
  localparam int CNT_W   = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

  localparam logic [WIDTH_W-1:0] WIDTH_RST  = 11'd640;
  localparam logic [ROW_W-1:0]   HEIGHT_RST = 16'd480;

  // Reciprocals (scaled by 2^16) for the odd neighbor counts.
  localparam logic [14:0] RECIP_3 = 15'd21846;
  localparam logic [14:0] RECIP_9 = 15'd7282;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_SUM,
    S_DIV,
    S_OUT
  } state_t;

  // Which of the nine window cells count, and how many do.
  typedef struct packed {
    logic [8:0]       en;
    logic [CNT_W-1:0] cnt;
  } lane_sel_t;

endpackage

[src/box_blur_3x3_edge_aware.sv]
// Top level of the edge-aware 3x3 box blur.
//
// Usage:
//  - in_*: one RGB pixel per request, raster order, valid/ready.
//  - cfg_*: register writes (index 0 width, 1 height); cfg_ready is high
//    whenever reset is released. Write only while the block is idle.
//  - out_*: blurred pixels with row/column tags, valid/ready. Pixel (r,c)
//    yields the result for (r-1,c-1); row ends and the last row add more,
//    up to four results per pixel. out_run_last marks the last result of a
//    pixel, out_frame_end the image's final pixel.
// Timing: one pixel is handled at a time. Accept, then the registered line
//  buffer read (S_LOAD), then per result the states sum, divide and present
//  (S_SUM, S_DIV, S_OUT) plus any output stall. The shared window register
//  and single line buffer port set this sequence.
// Three color lanes sum and divide in parallel; the top merges them with
//  the position tags.
// Reset: synchronous, active low. Positions and window clear, registers go
//  to 640x480. Line buffers are not cleared; border masking hides them.
// Stall: a waiting result holds its payload; no new pixel is taken.
module box_blur_3x3_edge_aware #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [bb3_pkg::PIX_W-1:0]       in_red,
  input  logic [bb3_pkg::PIX_W-1:0]       in_green,
  input  logic [bb3_pkg::PIX_W-1:0]       in_blue,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bb3_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bb3_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [bb3_pkg::PIX_W-1:0]       out_red,
  output logic [bb3_pkg::PIX_W-1:0]       out_green,
  output logic [bb3_pkg::PIX_W-1:0]       out_blue,
  output logic [bb3_pkg::ROW_W-1:0]       out_row,
  output logic [bb3_pkg::COL_W-1:0]       out_col,
  output logic                            out_run_last,
  output logic                            out_frame_end
);
  import bb3_pkg::*;
  `include "box_blur_3x3_edge_aware_defines.svh"

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  state_t state_r, state_nxt;

  logic [WIDTH_W-1:0] width_r;
  logic [ROW_W-1:0]   height_r;
  logic [ROW_W-1:0]   row_pos_r;
  logic [COL_W-1:0]   col_pos_r;

  // latched per pixel
  logic [RGB_W-1:0] pix_r;
  logic [ROW_W-1:0] r_r;
  logic [COL_W-1:0] c_r;
  logic             col_end_r, last_row_r;

  logic [2:0][RGB_W-1:0] win_c1_r, win_c2_r;  // rows 0..2 (r-2..r)
  logic [8:0][RGB_W-1:0] grid_r;              // cell = row*3 + col
  logic [3:0]            pend_r;
  logic [3:0]            pend_nxt_load;

  logic             accept;
  logic [COL_W-1:0] c_clamp;
  logic [31:0]      addr_full;
  logic [AW-1:0]    addr;
  logic [31:0]      w_eff;
  logic [ROW_W:0]   h_eff;
  logic             col_end, last_row;
  logic [RGB_W-1:0] rd_prev, rd_old;
  logic             load;

  assign accept    = in_valid && in_ready;
  assign cfg_ready = rst_n;
  assign load      = (state_r == S_LOAD);

  // effective geometry: zero acts as one, width capped at MAX_WIDTH
  always_comb begin
    c_clamp = (32'(col_pos_r) >= 32'(MAX_WIDTH)) ? COL_W'(MAX_WIDTH - 1) : col_pos_r;
    addr_full = 32'(c_clamp);
    if (width_r == '0) w_eff = 32'd1;
    else if (32'(width_r) > 32'(MAX_WIDTH)) w_eff = 32'(MAX_WIDTH);
    else w_eff = 32'(width_r);
    h_eff    = (height_r == '0) ? (ROW_W+1)'(1) : {1'b0, height_r};
    col_end  = (32'(c_clamp) + 32'd1) >= w_eff;
    last_row = ({1'b0, row_pos_r} + (ROW_W+1)'(1)) >= h_eff;
  end
  assign addr = addr_full[AW-1:0];

  bb3_linebuf #(.DEPTH(MAX_WIDTH), .AW(AW)) u_linebuf (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (addr),
    .wr_en   (load),
    .wr_addr (AW'(c_r)),
    .wr_prev (pix_r),
    .wr_old  (rd_prev),
    .rd_prev (rd_prev),
    .rd_old  (rd_old)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_data[WIDTH_W-1:0];
        REG_HEIGHT: height_r <= cfg_data[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // current result: lowest pending bit
  logic [3:0] low_bit;
  logic       cur_j2, cur_k2;
  logic [2:0] vr, vc, row_en, col_en;
  logic [1:0] nrow, ncol;
  lane_sel_t  sel;

  always_comb begin
    low_bit = pend_r & (~pend_r + 4'd1);
    cur_j2  = low_bit[2] || low_bit[3];
    cur_k2  = low_bit[1] || low_bit[3];
    vr      = {1'b1, r_r != '0, r_r > ROW_W'(1)};
    vc      = {1'b1, c_r != '0, c_r > COL_W'(1)};
    row_en  = cur_j2 ? {vr[2], vr[1], 1'b0} : vr;
    col_en  = cur_k2 ? {vc[2], vc[1], 1'b0} : vc;
    nrow    = 2'(row_en[0]) + 2'(row_en[1]) + 2'(row_en[2]);
    ncol    = 2'(col_en[0]) + 2'(col_en[1]) + 2'(col_en[2]);
    sel.cnt = CNT_W'(nrow) * CNT_W'(ncol);
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        sel.en[i*3+k] = row_en[i] && col_en[k];
      end
    end
  end

  // color lanes
  logic [2:0][8:0][PIX_W-1:0] lane_cells;
  logic [2:0][PIX_W-1:0]      lane_mean;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int i = 0; i < 9; i++) begin
        lane_cells[ch][i] = grid_r[i][ch*PIX_W +: PIX_W];
      end
    end
  end

  for (genvar ch = 0; ch < 3; ch++) begin : g_lane
    bb3_lane u_lane (
      .clk   (clk),
      .sel   (sel),
      .cells (lane_cells[ch]),
      .mean  (lane_mean[ch])
    );
  end

  // merge: colors plus position tags
  assign out_red       = lane_mean[0];
  assign out_green     = lane_mean[1];
  assign out_blue      = lane_mean[2];
  assign out_row       = cur_j2 ? r_r : r_r - ROW_W'(1);
  assign out_col       = cur_k2 ? c_r : c_r - COL_W'(1);
  assign out_run_last  = (pend_r & ~low_bit) == 4'd0;
  assign out_frame_end = low_bit[3];

  assign pend_nxt_load = {last_row_r && col_end_r,
                          last_row_r && (c_r != '0),
                          (r_r != '0) && col_end_r,
                          (r_r != '0) && (c_r != '0)};

  // sequencer
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = rst_n;
        if (in_valid) state_nxt = S_LOAD;
      end
      S_LOAD: begin
        state_nxt = (pend_nxt_load != 4'd0) ? S_SUM : S_IDLE;
      end
      S_SUM: state_nxt = S_DIV;
      S_DIV: state_nxt = S_OUT;
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = out_run_last ? S_IDLE : S_SUM;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      row_pos_r <= '0;
      col_pos_r <= '0;
      pend_r    <= '0;
      win_c1_r  <= '0;
      win_c2_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        if (col_end) begin
          col_pos_r <= '0;
          row_pos_r <= last_row ? '0 : row_pos_r + ROW_W'(1);
        end else begin
          col_pos_r <= c_clamp + COL_W'(1);
        end
      end
      if (load) begin
        pend_r   <= pend_nxt_load;
        win_c2_r <= win_c1_r;
        win_c1_r <= {pix_r, rd_prev, rd_old};
      end else if (state_r == S_OUT && out_ready) begin
        pend_r <= pend_r & ~low_bit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix_r      <= {in_blue, in_green, in_red};
      r_r        <= row_pos_r;
      c_r        <= c_clamp;
      col_end_r  <= col_end;
      last_row_r <= last_row;
    end
    if (load) begin
      for (int i = 0; i < 3; i++) begin
        grid_r[i*3+0] <= win_c2_r[i];
        grid_r[i*3+1] <= win_c1_r[i];
      end
      grid_r[2] <= rd_old;
      grid_r[5] <= rd_prev;
      grid_r[8] <= pix_r;
    end
  end

  `BB3_ASSERT(a_one_side, !(out_valid && in_ready), "input taken while a result waits")
  `BB3_ASSERT(a_load_follows, accept |=> (state_r == S_LOAD), "no line buffer load after accept")
  `BB3_ASSERT(a_frame_last, (out_valid && out_frame_end) |-> out_run_last, "frame end not last")
  `BB3_ASSERT_ALWAYS(a_rst_idle, !rst_n |=> (state_r == S_IDLE), "not idle after reset")

endmodule

[src/bb3_linebuf.sv]
// Two line buffers holding the previous and older rows.
module bb3_linebuf #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                  clk,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  logic [bb3_pkg::RGB_W-1:0] wr_prev,
  input  logic [bb3_pkg::RGB_W-1:0] wr_old,
  output logic [bb3_pkg::RGB_W-1:0] rd_prev,
  output logic [bb3_pkg::RGB_W-1:0] rd_old
);
  import bb3_pkg::*;

  logic [RGB_W-1:0] prev_mem [DEPTH];
  logic [RGB_W-1:0] old_mem  [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      prev_mem[wr_addr] <= wr_prev;
      old_mem[wr_addr]  <= wr_old;
    end
    if (rd_en) begin
      rd_prev <= prev_mem[rd_addr];
      rd_old  <= old_mem[rd_addr];
    end
  end

endmodule

[src/bb3_lane.sv]
// One color lane: masked window sum, then rounded division by the count.
module bb3_lane (
  input  logic                          clk,
  input  bb3_pkg::lane_sel_t            sel,
  input  logic [8:0][bb3_pkg::PIX_W-1:0] cells,
  output logic [bb3_pkg::PIX_W-1:0]     mean
);
  import bb3_pkg::*;

  logic [SUM_W-1:0] sum_nxt, sum_r, x;
  logic [CNT_W-1:0] cnt_r;
  logic [26:0]      p3, p9;
  logic [PIX_W-1:0] q_nxt, q_r;

  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < 9; i++) begin
      if (sel.en[i]) sum_nxt = sum_nxt + SUM_W'(cells[i]);
    end
  end

  // round half up: (sum + cnt/2) / cnt
  assign x  = sum_r + SUM_W'(cnt_r >> 1);
  assign p3 = 27'(x) * 27'(RECIP_3);
  assign p9 = 27'(x) * 27'(RECIP_9);

  always_comb begin
    case (cnt_r)
      4'd2:    q_nxt = x[PIX_W:1];
      4'd3:    q_nxt = p3[16 +: PIX_W];
      4'd4:    q_nxt = x[PIX_W+1:2];
      4'd6:    q_nxt = p3[17 +: PIX_W];
      4'd9:    q_nxt = p9[16 +: PIX_W];
      default: q_nxt = x[PIX_W-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
    cnt_r <= sel.cnt;
    q_r   <= q_nxt;
  end

  assign mean = q_r;

endmodule
